/* hdl/mspfe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mspfe_pkg;

	// Item kinds carried in the input tuser bit.
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_DATA  = 1'b1;

	// Framing versions.
	localparam logic VER_1 = 1'b0;
	localparam logic VER_2 = 1'b1;

	localparam logic [7:0]  SOF_CHAR   = 8'h24;
	localparam logic [7:0]  V1_MARK    = 8'h4D;
	localparam logic [7:0]  V2_MARK    = 8'h58;
	localparam logic [7:0]  V2_FLAG    = 8'h00;
	localparam logic [15:0] V1_MAX_LEN = 16'd255;
	localparam logic [7:0]  CRC_POLY   = 8'hD5;

	// Longest burst one item can cause: a version 2 header plus its check byte.
	localparam int MAX_BEATS = 9;
	localparam int CNT_W     = $clog2(MAX_BEATS + 1);

	typedef struct packed {
		logic [MAX_BEATS-1:0][7:0] bytes;
		logic [CNT_W-1:0]          count;
		logic                      has_check;
	} burst_t;

	// One byte through CRC8 DVB-S2, most significant bit first.
	function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* hdl/mspfe_burst_out.sv */
`timescale 1ns / 1ps
`default_nettype none

module mspfe_burst_out (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            load,
	input  wire mspfe_pkg::burst_t burst,
	output logic                 free,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [7:0]           m_tdata,   // out_byte
	output logic                 m_tlast,   // run_last
	output logic                 m_tuser    // frame_end
);

	logic [mspfe_pkg::MAX_BEATS-1:0][7:0] bytes_q;
	logic [mspfe_pkg::CNT_W-1:0]          cnt_q;
	logic                                 chk_q;
	logic                                 last_beat;

	assign last_beat = (cnt_q == mspfe_pkg::CNT_W'(1));
	assign m_tvalid  = (cnt_q != '0);
	assign m_tdata   = bytes_q[0];
	assign m_tlast   = last_beat;
	assign m_tuser   = chk_q && last_beat;

	// The register can take a new burst when empty or when its final beat leaves now.
	assign free = (cnt_q == '0) || (m_tready && last_beat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			chk_q <= 1'b0;
		end else if (load) begin
			cnt_q <= burst.count;
			chk_q <= burst.has_check;
		end else if (m_tvalid && m_tready) begin
			cnt_q <= cnt_q - mspfe_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= burst.bytes;
		end else if (m_tvalid && m_tready) begin
			for (int i = 0; i < mspfe_pkg::MAX_BEATS - 1; i++) begin
				bytes_q[i] <= bytes_q[i+1];
			end
			bytes_q[mspfe_pkg::MAX_BEATS-1] <= 8'h00;
		end
	end

endmodule

`default_nettype wire

/* hdl/msp_frame_encoder_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Frame encoder for a byte-serial link, version 1 and version 2 framing.
// Input channel (s_*): one beat per item. tuser is the kind: a start beat
// carries version, direction, function code and payload length; a data beat
// carries one payload byte. Output channel (m_*): one framed byte per beat,
// tlast on the final byte caused by an input beat, tuser on the check byte.
// A start beat expands into 5 (version 1) or 8 (version 2) header bytes, plus
// the check byte when the payload is empty. A data beat gives its byte and,
// on the last payload byte, the check byte. Oversized version 1 frames and
// data beats with no open frame give no output.
// The input register loads on the accepting edge and the burst register
// loads from it once the burst register is free.
// Throughput: one input beat per cycle while each item gives at most one
// byte and the receiver does not stall; otherwise the input register holds
// a new item while the single-byte output port drains the burst register,
// which takes a new burst as its final byte leaves.
// When the receiver stalls, the burst register holds and the input register
// fills, after which s_tready drops. Reset clears all frame state and empties
// both registers.
module msp_frame_encoder_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,   // version, direction[8], function_code[16],
	                                    // payload_length[16], data_byte[8], zero pad
	input  wire logic        s_tuser,   // cmd
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // out_byte
	output logic             m_tlast,   // run_last
	output logic             m_tuser    // frame_end
);

	// Input field unpacking.
	logic        in_ver;
	logic [7:0]  in_dir;
	logic [15:0] in_func;
	logic [15:0] in_len;
	logic [7:0]  in_data;

	assign in_ver  = s_tdata[0];
	assign in_dir  = s_tdata[8:1];
	assign in_func = s_tdata[24:9];
	assign in_len  = s_tdata[40:25];
	assign in_data = s_tdata[48:41];

	// Input register. The version 2 header CRC depends only on the start beat,
	// so it is worked out on the way in.
	logic        valid_s1;
	logic        cmd_s1;
	logic        ver_s1;
	logic [7:0]  dir_s1;
	logic [15:0] func_s1;
	logic [15:0] len_s1;
	logic [7:0]  data_s1;
	logic [7:0]  hcrc_s1;
	logic [7:0]  hcrc_in;

	assign hcrc_in = mspfe_pkg::crc_step(
		mspfe_pkg::crc_step(
			mspfe_pkg::crc_step(
				mspfe_pkg::crc_step(
					mspfe_pkg::crc_step(8'h00, mspfe_pkg::V2_FLAG),
					in_func[7:0]),
				in_func[15:8]),
			in_len[7:0]),
		in_len[15:8]);

	// Frame state.
	logic        open_q;
	logic        fver_q;
	logic        drop_q;
	logic [15:0] left_q;
	logic [7:0]  acc_q;

	logic        open_n;
	logic        fver_n;
	logic        drop_n;
	logic [15:0] left_n;
	logic [7:0]  acc_n;

	mspfe_pkg::burst_t burst;
	logic              out_free;
	logic              adv;
	logic              load;
	logic              in_fire;

	assign adv      = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign in_fire  = s_tvalid && s_tready;
	assign load     = adv && (burst.count != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1  <= s_tuser;
			ver_s1  <= in_ver;
			dir_s1  <= in_dir;
			func_s1 <= in_func;
			len_s1  <= in_len;
			data_s1 <= in_data;
			hcrc_s1 <= hcrc_in;
		end
	end

	// Burst builder: the whole output of one item and the next frame state.
	always_comb begin
		open_n = open_q;
		fver_n = fver_q;
		drop_n = drop_q;
		left_n = left_q;
		acc_n  = acc_q;
		burst  = '0;
		unique case (cmd_s1)
			mspfe_pkg::CMD_START: begin
				open_n = 1'b1;
				fver_n = ver_s1;
				drop_n = 1'b0;
				left_n = len_s1;
				acc_n  = 8'h00;
				if (ver_s1 == mspfe_pkg::VER_1) begin
					if (len_s1 >= mspfe_pkg::V1_MAX_LEN) begin
						// Too long for version 1: swallow the whole frame.
						drop_n = 1'b1;
					end else begin
						burst.bytes[0] = mspfe_pkg::SOF_CHAR;
						burst.bytes[1] = mspfe_pkg::V1_MARK;
						burst.bytes[2] = dir_s1;
						burst.bytes[3] = len_s1[7:0];
						burst.bytes[4] = func_s1[7:0];
						burst.count    = mspfe_pkg::CNT_W'(5);
						acc_n          = len_s1[7:0] ^ func_s1[7:0];
						if (len_s1 == 16'd0) begin
							burst.bytes[5]  = acc_n;
							burst.count     = mspfe_pkg::CNT_W'(6);
							burst.has_check = 1'b1;
							open_n          = 1'b0;
						end
					end
				end else begin
					burst.bytes[0] = mspfe_pkg::SOF_CHAR;
					burst.bytes[1] = mspfe_pkg::V2_MARK;
					burst.bytes[2] = dir_s1;
					burst.bytes[3] = mspfe_pkg::V2_FLAG;
					burst.bytes[4] = func_s1[7:0];
					burst.bytes[5] = func_s1[15:8];
					burst.bytes[6] = len_s1[7:0];
					burst.bytes[7] = len_s1[15:8];
					burst.count    = mspfe_pkg::CNT_W'(8);
					acc_n          = hcrc_s1;
					if (len_s1 == 16'd0) begin
						burst.bytes[8]  = acc_n;
						burst.count     = mspfe_pkg::CNT_W'(9);
						burst.has_check = 1'b1;
						open_n          = 1'b0;
					end
				end
			end
			mspfe_pkg::CMD_DATA: begin
				if (open_q && (left_q != 16'd0)) begin
					left_n = left_q - 16'd1;
					if (drop_q) begin
						if (left_n == 16'd0) begin
							open_n = 1'b0;
							drop_n = 1'b0;
						end
					end else begin
						burst.bytes[0] = data_s1;
						burst.count    = mspfe_pkg::CNT_W'(1);
						if (fver_q == mspfe_pkg::VER_2) begin
							acc_n = mspfe_pkg::crc_step(acc_q, data_s1);
						end else begin
							acc_n = acc_q ^ data_s1;
						end
						if (left_n == 16'd0) begin
							burst.bytes[1]  = acc_n;
							burst.count     = mspfe_pkg::CNT_W'(2);
							burst.has_check = 1'b1;
							open_n          = 1'b0;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			fver_q <= 1'b0;
			drop_q <= 1'b0;
			left_q <= 16'd0;
			acc_q  <= 8'h00;
		end else if (adv) begin
			open_q <= open_n;
			fver_q <= fver_n;
			drop_q <= drop_n;
			left_q <= left_n;
			acc_q  <= acc_n;
		end
	end

	mspfe_burst_out u_burst_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.burst    (burst),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

`ifndef SYNTHESIS
	// The check byte always closes the run of the item that caused it.
	a_check_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast)
		else $error("check byte without tlast");

	// A burst is loaded only into an output register that is empty or emptying.
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> out_free)
		else $error("burst loaded over pending output");

	// Only an open version 1 frame is ever dropped.
	a_drop_state: assert property (@(posedge clk) disable iff (!arst_n)
		drop_q |-> (open_q && (fver_q == mspfe_pkg::VER_1) && (left_q != 16'd0)))
		else $error("inconsistent drop state");
`endif

endmodule

`default_nettype wire
